// File: rtl/core/cnpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnpi_pkg
// Shared types and constants for the cached nearest palette index block.
// ----------------------------------------------------------------------------
package cnpi_pkg;

	localparam int PaletteDepthDef = 256;
	localparam int QuantBitsDef    = 6;
	localparam int Channels        = 3;
	localparam int EpochW          = 8;
	localparam int CfgIdxW         = 2;
	localparam int CfgDataW        = 9;

	localparam logic [CfgIdxW-1:0] REG_PACKING_MODE  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PALETTE_COUNT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_CACHE_WR_DIS  = 2'd2;

	localparam logic [1:0] PACK_MORTON  = 2'd1;
	localparam logic [1:0] PACK_HILBERT = 2'd2;

	localparam logic FUNC_PIXEL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_HILB,
		ST_KEY,
		ST_CRD,
		ST_CCHK,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic take;
		logic clr_step;
		logic hilb_step;
		logic key_load;
		logic cache_rd;
		logic res_hit;
		logic walk_start;
		logic walk_issue;
		logic res_miss;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_pend;
		logic clr_last;
		logic in_pixel;
		logic count_zero;
		logic hilb_done;
		logic hit;
		logic walk_last;
		logic walk_busy;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

// File: rtl/core/cnpi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnpi_ctrl
// Sequencer: clearing pass, key build, cache lookup, palette walk, result.
// ----------------------------------------------------------------------------
module cnpi_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  cnpi_pkg::status_t  status,
	output cnpi_pkg::cmd_t     cmd
);

	cnpi_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			cnpi_pkg::ST_IDLE: begin
				if (status.clr_pend) begin
					state_d = cnpi_pkg::ST_CLEAR;
				end else begin
					s_tready = 1'b1;
					if (s_tvalid) begin
						cmd.take = 1'b1;
						if (status.in_pixel && !status.count_zero) begin
							state_d = cnpi_pkg::ST_HILB;
						end else begin
							state_d = cnpi_pkg::ST_RESULT;
						end
					end
				end
			end
			cnpi_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = cnpi_pkg::ST_IDLE;
				end
			end
			cnpi_pkg::ST_HILB: begin
				if (status.hilb_done) begin
					state_d = cnpi_pkg::ST_KEY;
				end else begin
					cmd.hilb_step = 1'b1;
				end
			end
			cnpi_pkg::ST_KEY: begin
				cmd.key_load = 1'b1;
				state_d      = cnpi_pkg::ST_CRD;
			end
			cnpi_pkg::ST_CRD: begin
				cmd.cache_rd = 1'b1;
				state_d      = cnpi_pkg::ST_CCHK;
			end
			cnpi_pkg::ST_CCHK: begin
				if (status.hit) begin
					cmd.res_hit = 1'b1;
					state_d     = cnpi_pkg::ST_RESULT;
				end else begin
					cmd.walk_start = 1'b1;
					state_d        = cnpi_pkg::ST_WALK;
				end
			end
			cnpi_pkg::ST_WALK: begin
				cmd.walk_issue = 1'b1;
				if (status.walk_last) begin
					state_d = cnpi_pkg::ST_DRAIN;
				end
			end
			cnpi_pkg::ST_DRAIN: begin
				// wait for the distance pipeline to settle the best index
				if (!status.walk_busy) begin
					cmd.res_miss = 1'b1;
					state_d      = cnpi_pkg::ST_RESULT;
				end
			end
			cnpi_pkg::ST_RESULT: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = cnpi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cnpi_pkg::ST_IDLE;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (state_q == cnpi_pkg::ST_HILB || state_q == cnpi_pkg::ST_RESULT))
		else $error("item taken without starting its work");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_issue |-> $past(cmd.walk_start) || $past(cmd.walk_issue))
		else $error("walk issued without a start");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !status.clr_pend)
		else $error("item taken while clearing is pending");

endmodule
`default_nettype wire

// File: rtl/core/cnpi_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnpi_dp
// Datapath: registers, palette store, bucket cache, key build, distance pipe.
// ----------------------------------------------------------------------------
module cnpi_dp #(
	parameter int PALETTE_DEPTH = cnpi_pkg::PaletteDepthDef,
	parameter int QUANT_BITS    = cnpi_pkg::QuantBitsDef
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire [31:0]                       s_tdata,
	input  wire [0:0]                        s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [7:0]                       m_tdata,
	output logic [0:0]                       m_tuser,
	input  wire                              cfg_we,
	input  wire [cnpi_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire [cnpi_pkg::CfgDataW-1:0]     cfg_data,
	input  cnpi_pkg::cmd_t                   cmd,
	output cnpi_pkg::status_t                status
);

	localparam int AddrW      = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int QB         = QUANT_BITS;
	localparam int KeyW       = cnpi_pkg::Channels * QB;
	localparam int CacheDepth = 1 << KeyW;
	localparam int EntW       = 1 + cnpi_pkg::EpochW + 8;
	localparam int QS         = (QB < 8) ? 8 - QB : 0;
	localparam int Half       = (QS > 0) ? (1 << (QS - 1)) : 0;
	localparam int QMax       = (1 << QB) - 1;

	function automatic logic [QB-1:0] quant(input logic [7:0] c);
		logic [8:0] sum;
		logic [8:0] sh;
		logic [QB-1:0] r;
		sum = {1'b0, c} + 9'(Half);
		sh  = sum >> QS;
		if (QS > 0) begin
			r = (sh > 9'(QMax)) ? QB'(QMax) : QB'(sh);
		end else begin
			r = QB'(c);
		end
		return r;
	endfunction

	// configuration
	logic [1:0] mode_q;
	logic [8:0] pcount_q;
	logic       wr_dis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			pcount_q <= '0;
			wr_dis_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cnpi_pkg::REG_PACKING_MODE:  mode_q   <= cfg_data[1:0];
				cnpi_pkg::REG_PALETTE_COUNT: pcount_q <= cfg_data;
				cnpi_pkg::REG_CACHE_WR_DIS:  wr_dis_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [8:0]       count_clip;
	logic [AddrW-1:0] count_m1;
	assign count_clip = (pcount_q > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : pcount_q;
	assign count_m1   = AddrW'(count_clip - 9'd1);

	// input fields
	logic [7:0] in_slot, in_c0, in_c1, in_c2;
	logic       in_func, slot_ok, pal_wr;
	assign in_slot = s_tdata[7:0];
	assign in_c0   = s_tdata[15:8];
	assign in_c1   = s_tdata[23:16];
	assign in_c2   = s_tdata[31:24];
	assign in_func = s_tuser[0];
	assign slot_ok = {1'b0, in_slot} < 9'(PALETTE_DEPTH);
	assign pal_wr  = cmd.take && (in_func != cnpi_pkg::FUNC_PIXEL) && slot_ok;

	// palette store; an entry never written reads as zero
	logic [23:0]              pal_mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] pal_vld_q;

	always_ff @(posedge clk) begin
		if (pal_wr) begin
			pal_mem[in_slot[AddrW-1:0]] <= {in_c2, in_c1, in_c0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q <= '0;
		end else if (pal_wr) begin
			pal_vld_q[in_slot[AddrW-1:0]] <= 1'b1;
		end
	end

	// epoch and clearing pass
	logic [cnpi_pkg::EpochW-1:0] epoch_q;
	logic [KeyW-1:0]             clr_cnt_q;
	logic                        clr_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q    <= '0;
			clr_cnt_q  <= '0;
			clr_pend_q <= 1'b1;
		end else begin
			if (pal_wr) begin
				epoch_q <= epoch_q + 1'b1;
				// epoch wraps: old marks would come back to life, so wipe
				if (&epoch_q) begin
					clr_pend_q <= 1'b1;
				end
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q) begin
					clr_pend_q <= 1'b0;
				end
			end
		end
	end

	// pixel registers and Hilbert iteration
	logic [7:0]    c0_q, c1_q, c2_q;
	logic [QB-1:0] q0_q, q1_q, q2_q, x0_q, x1_q, x2_q, hlev_q;
	logic [QB-1:0] a0, a1, a2, m, t;

	always_comb begin
		a0 = x0_q;
		a1 = x1_q;
		a2 = x2_q;
		t  = '0;
		m  = hlev_q - 1'b1;
		if ((a0 & hlev_q) != '0) begin
			a0 = a0 ^ m;
		end
		if ((a1 & hlev_q) != '0) begin
			a0 = a0 ^ m;
		end else begin
			t  = (a0 ^ a1) & m;
			a0 = a0 ^ t;
			a1 = a1 ^ t;
		end
		if ((a2 & hlev_q) != '0) begin
			a0 = a0 ^ m;
		end else begin
			t  = (a0 ^ a2) & m;
			a0 = a0 ^ t;
			a2 = a2 ^ t;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			c0_q   <= in_c0;
			c1_q   <= in_c1;
			c2_q   <= in_c2;
			q0_q   <= quant(in_c2);
			q1_q   <= quant(in_c1);
			q2_q   <= quant(in_c0);
			x0_q   <= quant(in_c2);
			x1_q   <= quant(in_c1);
			x2_q   <= quant(in_c0);
			hlev_q <= QB'(1) << (QB - 1);
		end else if (cmd.hilb_step) begin
			x0_q   <= a0;
			x1_q   <= a1;
			x2_q   <= a2;
			hlev_q <= hlev_q >> 1;
		end
	end

	// key build
	logic [QB-1:0]   g1, g2, tf, h0, h1, h2;
	logic [KeyW-1:0] key_morton, key_hilbert, key_linear, key_sel, key_q;

	always_comb begin
		g1 = x1_q ^ x0_q;
		g2 = x2_q ^ g1;
		for (int j = 0; j < QB; j++) begin
			tf[j] = 1'b0;
			for (int k = j + 1; k < QB; k++) begin
				tf[j] = tf[j] ^ g2[k];
			end
		end
		h0 = x0_q ^ tf;
		h1 = g1 ^ tf;
		h2 = g2 ^ tf;
		for (int b = 0; b < QB; b++) begin
			key_morton[3*b]      = q0_q[b];
			key_morton[3*b+1]    = q1_q[b];
			key_morton[3*b+2]    = q2_q[b];
			key_hilbert[3*b]     = h0[b];
			key_hilbert[3*b+1]   = h1[b];
			key_hilbert[3*b+2]   = h2[b];
		end
		key_linear = {q2_q, q1_q, q0_q};
		unique case (mode_q)
			cnpi_pkg::PACK_MORTON:  key_sel = key_morton;
			cnpi_pkg::PACK_HILBERT: key_sel = key_hilbert;
			default:                key_sel = key_linear;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= key_sel;
		end
	end

	// distance pipeline
	logic [AddrW-1:0] idx_q, idx_a, idx_b, best_q;
	logic             v_a, v_b;
	logic [23:0]      pal_rd_a;
	logic             vld_a;
	logic [15:0]      sq0_b, sq1_b, sq2_b;
	logic [17:0]      best_d_q, d_sum;
	logic [23:0]      ent;
	logic [7:0]       ad0, ad1, ad2;

	assign ent   = vld_a ? pal_rd_a : 24'd0;
	assign ad0   = (c0_q > ent[7:0])   ? c0_q - ent[7:0]   : ent[7:0] - c0_q;
	assign ad1   = (c1_q > ent[15:8])  ? c1_q - ent[15:8]  : ent[15:8] - c1_q;
	assign ad2   = (c2_q > ent[23:16]) ? c2_q - ent[23:16] : ent[23:16] - c2_q;
	assign d_sum = 18'(sq0_b) + 18'(sq1_b) + 18'(sq2_b);

	always_ff @(posedge clk) begin
		if (cmd.walk_issue) begin
			pal_rd_a <= pal_mem[idx_q];
			vld_a    <= pal_vld_q[idx_q];
			idx_a    <= idx_q;
		end
		sq0_b <= ad0 * ad0;
		sq1_b <= ad1 * ad1;
		sq2_b <= ad2 * ad2;
		idx_b <= idx_a;
		if (cmd.walk_start) begin
			idx_q    <= '0;
			best_q   <= '0;
			best_d_q <= '1;
		end else begin
			if (cmd.walk_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (v_b && (d_sum < best_d_q)) begin
				best_d_q <= d_sum;
				best_q   <= idx_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_a <= 1'b0;
			v_b <= 1'b0;
		end else begin
			v_a <= cmd.walk_issue;
			v_b <= v_a;
		end
	end

	// bucket cache: valid, epoch, index
	logic [EntW-1:0] cache_mem [CacheDepth];
	logic [EntW-1:0] cache_rd_q;
	logic            cache_wr;

	assign cache_wr = cmd.res_miss && !wr_dis_q;

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			cache_mem[clr_cnt_q] <= '0;
		end else if (cache_wr) begin
			cache_mem[key_q] <= {1'b1, epoch_q, 8'(best_q)};
		end
		if (cmd.cache_rd) begin
			cache_rd_q <= cache_mem[key_q];
		end
	end

	// result and output register
	logic [7:0] res_idx_q, out_idx_q;
	logic       res_hit_q, out_hit_q, out_vld_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			res_idx_q <= '0;
			res_hit_q <= 1'b0;
		end else if (cmd.res_hit) begin
			res_idx_q <= cache_rd_q[7:0];
			res_hit_q <= 1'b1;
		end else if (cmd.res_miss) begin
			res_idx_q <= 8'(best_q);
			res_hit_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_idx_q <= res_idx_q;
			out_hit_q <= res_hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_idx_q;
	assign m_tuser  = out_hit_q;

	assign status.clr_pend   = clr_pend_q;
	assign status.clr_last   = &clr_cnt_q;
	assign status.in_pixel   = (in_func == cnpi_pkg::FUNC_PIXEL);
	assign status.count_zero = (count_clip == 9'd0);
	assign status.hilb_done  = ((hlev_q >> 1) == '0);
	assign status.hit        = cache_rd_q[EntW-1] && (cache_rd_q[8 +: cnpi_pkg::EpochW] == epoch_q);
	assign status.walk_last  = (idx_q == count_m1);
	assign status.walk_busy  = v_a || v_b;
	assign status.out_busy   = out_vld_q && !m_tready;

	assert property (@(posedge clk) disable iff (!arst_n)
		cache_wr |-> !clr_pend_q)
		else $error("cache fill while a clearing pass is pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_vld_q && !m_tready))
		else $error("output register overwritten before transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_miss |-> !v_a && !v_b)
		else $error("miss result taken before the walk settled");

endmodule
`default_nettype wire

// File: rtl/core/cached_nearest_palette_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cached_nearest_palette_index
// Nearest palette index search with a quantized bucket cache.
// ----------------------------------------------------------------------------
// Takes one item at a time. A palette write, and a pixel with an empty palette,
// go straight to the result state and then to the output register. Any other
// pixel runs the Hilbert iteration, one level per cycle, then key, cache read
// and check; a hit goes on to the result, and a miss first walks the palette up
// to the clipped palette count: the walk reads one palette entry per cycle from a
// single memory port through a three-stage distance pipeline. After reset and
// after every 256th palette write the cache is wiped by a clearing pass over
// every cache entry, during which no item is taken; configuration writes are
// taken at any time.
module cached_nearest_palette_index #(
	parameter int PALETTE_DEPTH = cnpi_pkg::PaletteDepthDef,
	parameter int QUANT_BITS    = cnpi_pkg::QuantBitsDef
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [31:0]                   s_tdata,   // entry_index, chan0, chan1, chan2
	input  wire [0:0]                    s_tuser,   // func
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [7:0]                   m_tdata,   // color_index
	output logic [0:0]                   m_tuser,   // from_cache
	input  wire                          cfg_we,
	input  wire [cnpi_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire [cnpi_pkg::CfgDataW-1:0] cfg_data
);

	cnpi_pkg::cmd_t    cmd;
	cnpi_pkg::status_t status;

	cnpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cnpi_dp #(
		.PALETTE_DEPTH (PALETTE_DEPTH),
		.QUANT_BITS    (QUANT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
`default_nettype wire
